/* design/sst_pkg.sv */
// Package for the sorted span table: command and status codes, operation class type.
// No dependencies.
package sst_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_NEXT   = 3'd2;
    localparam logic [2:0] CMD_PREV   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int TAG_BITS  = 16;
    localparam int SLOT_BITS = 8;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_NEXT   = 3'd2,
        OP_PREV   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_BAD    = 3'd5
    } t_op;

endpackage

/* design/sorted_span_table.sv */
// Sorted span table: a two-entry command queue in front of a sequencer that owns the span memory.
// Clear, unknown commands, a full or empty table go straight to the result; an append writes past
// the last entry; lookup is a binary search; closest scans all entries; other inserts shift.
// One command runs at a time and two more may wait; busy is high while the queue is full.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, active low) empties the table and zeroes the probe cache.
module sorted_span_table import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             i_cmd,
    input  logic [LINE_BITS-1:0]   i_line,
    input  logic [COLUMN_BITS-1:0] i_column,
    input  logic [LINE_BITS-1:0]   i_stop_line,
    input  logic [COLUMN_BITS-1:0] i_stop_column,
    input  logic [TAG_BITS-1:0]    i_tag,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic [LINE_BITS-1:0]   o_hit_line,
    output logic [COLUMN_BITS-1:0] o_hit_column,
    output logic [LINE_BITS-1:0]   o_hit_stop_line,
    output logic [COLUMN_BITS-1:0] o_hit_stop_column,
    output logic [TAG_BITS-1:0]    o_hit_tag
);
    logic                   w_full, w_valid, w_pop;
    logic [2:0]             w_op;
    logic [LINE_BITS-1:0]   w_line, w_sline;
    logic [COLUMN_BITS-1:0] w_col, w_scol;
    logic [TAG_BITS-1:0]    w_tag;

    assign busy = w_full;

    sst_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
        .i_clk, .i_rst_n, .i_take(start && !busy),
        .i_cmd, .i_line, .i_column, .i_stop_line, .i_stop_column, .i_tag,
        .o_full(w_full), .o_valid(w_valid), .i_pop(w_pop),
        .o_op(w_op), .o_line(w_line), .o_column(w_col),
        .o_stop_line(w_sline), .o_stop_column(w_scol), .o_tag(w_tag)
    );

    sst_back #(.TABLE_DEPTH(TABLE_DEPTH), .LINE_BITS(LINE_BITS),
               .COLUMN_BITS(COLUMN_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .o_pop(w_pop),
        .i_op(w_op), .i_line(w_line), .i_column(w_col),
        .i_stop_line(w_sline), .i_stop_column(w_scol), .i_tag(w_tag),
        .o_done, .o_status, .o_slot, .o_hit_line, .o_hit_column,
        .o_hit_stop_line, .o_hit_stop_column, .o_hit_tag
    );
endmodule

/* design/sst_front.sv */
// Front end of the sorted span table: takes commands, classifies them and
// holds them in a two-entry queue for the back end. Uses sst_pkg.
module sst_front import sst_pkg::*; #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [2:0]              i_cmd,
    input  logic [LINE_BITS-1:0]    i_line,
    input  logic [COLUMN_BITS-1:0]  i_column,
    input  logic [LINE_BITS-1:0]    i_stop_line,
    input  logic [COLUMN_BITS-1:0]  i_stop_column,
    input  logic [TAG_BITS-1:0]     i_tag,
    output logic                    o_full,
    output logic                    o_valid,
    input  logic                    i_pop,
    output logic [2:0]              o_op,
    output logic [LINE_BITS-1:0]    o_line,
    output logic [COLUMN_BITS-1:0]  o_column,
    output logic [LINE_BITS-1:0]    o_stop_line,
    output logic [COLUMN_BITS-1:0]  o_stop_column,
    output logic [TAG_BITS-1:0]     o_tag
);
    localparam int EW = 3 + 2*LINE_BITS + 2*COLUMN_BITS + TAG_BITS;

    logic [EW-1:0] r_q [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_cnt;
    t_op           w_op;

    always_comb begin
        case (i_cmd)
            CMD_INSERT: w_op = OP_INSERT;
            CMD_LOOKUP: w_op = OP_LOOKUP;
            CMD_NEXT:   w_op = OP_NEXT;
            CMD_PREV:   w_op = OP_PREV;
            CMD_CLEAR:  w_op = OP_CLEAR;
            default:    w_op = OP_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_q[r_wr] <= {w_op, i_line, i_column, i_stop_line, i_stop_column, i_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_take) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_take} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign {o_op, o_line, o_column, o_stop_line, o_stop_column, o_tag} = r_q[r_rd];
endmodule

/* design/sst_back.sv */
// Back end of the sorted span table: span memory and the sequencer that runs
// insert, lookup, closest and clear. Uses sst_pkg.
module sst_back import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_pop,
    input  logic [2:0]              i_op,
    input  logic [LINE_BITS-1:0]    i_line,
    input  logic [COLUMN_BITS-1:0]  i_column,
    input  logic [LINE_BITS-1:0]    i_stop_line,
    input  logic [COLUMN_BITS-1:0]  i_stop_column,
    input  logic [TAG_BITS-1:0]     i_tag,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [SLOT_BITS-1:0]    o_slot,
    output logic [LINE_BITS-1:0]    o_hit_line,
    output logic [COLUMN_BITS-1:0]  o_hit_column,
    output logic [LINE_BITS-1:0]    o_hit_stop_line,
    output logic [COLUMN_BITS-1:0]  o_hit_stop_column,
    output logic [TAG_BITS-1:0]     o_hit_tag
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int KW = LINE_BITS + COLUMN_BITS;
    localparam int EW = 2*KW + TAG_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_FIND  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_PROBE = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdat;
    logic [AW-1:0] r_raddr, n_raddr;
    logic          r_we, n_we;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [EW-1:0] r_wdat, n_wdat;

    t_state        r_st, n_st;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_cache, n_cache;
    logic [2:0]    r_op, n_op;
    logic [KW-1:0] r_pt, n_pt;
    logic [EW-1:0] r_new, n_new;
    logic [CW-1:0] r_idx, n_idx;     // scan index or shift position
    logic [CW-1:0] r_b, n_b, r_e, n_e;
    logic          r_have, n_have;
    logic [AW-1:0] r_best, n_best;
    logic [KW-1:0] r_bkey, n_bkey;
    logic [EW-1:0] r_bent, n_bent;
    logic          r_done, n_done;
    logic [1:0]    r_stat, n_stat;
    logic [AW-1:0] r_slot, n_slot;
    logic [EW-1:0] r_hit, n_hit;

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdat;
        r_rdat <= r_mem[n_raddr];
    end

    logic [KW-1:0] w_skey, w_ekey;
    logic          w_neg;
    logic [CW-1:0] w_mid;
    assign w_skey = r_rdat[EW-1 -: KW];
    assign w_ekey = r_rdat[EW-KW-1 -: KW];
    assign w_neg  = r_rdat[TAG_BITS-1];

    always_comb begin
        n_st = r_st; n_count = r_count; n_cache = r_cache; n_op = r_op;
        n_pt = r_pt; n_new = r_new; n_idx = r_idx; n_b = r_b; n_e = r_e;
        n_have = r_have; n_best = r_best; n_bkey = r_bkey; n_bent = r_bent;
        n_done = 1'b0; n_stat = r_stat; n_slot = r_slot; n_hit = r_hit;
        n_raddr = r_raddr; n_we = 1'b0; n_waddr = r_waddr; n_wdat = r_wdat;
        w_mid = '0;
        o_pop = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_op  = i_op;
                    n_pt  = {i_line, i_column};
                    n_new = {i_line, i_column, i_stop_line, i_stop_column, i_tag};
                    n_stat = ST_OK; n_slot = '0; n_hit = '0;
                    n_have = 1'b0; n_idx = '0;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_stat = ST_FULL; n_st = S_EMIT;
                            end else if (r_count == '0) begin
                                n_we = 1'b1; n_waddr = '0;
                                n_wdat = {i_line, i_column, i_stop_line, i_stop_column, i_tag};
                                n_count = r_count + 1'b1; n_st = S_EMIT;
                            end else begin
                                n_raddr = AW'(r_count - 1'b1); n_st = S_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_stat = ST_NONE; n_st = S_EMIT;
                            end else begin
                                if ({1'b0, r_cache} >= r_count) n_cache = '0;
                                n_raddr = ({1'b0, r_cache} >= r_count) ? '0 : r_cache;
                                n_b = '0; n_e = r_count - 1'b1;
                                n_st = S_RD;
                            end
                        end
                        OP_NEXT, OP_PREV: begin
                            if (r_count == '0) begin
                                n_stat = ST_NONE; n_st = S_EMIT;
                            end else begin
                                n_raddr = '0; n_st = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0; n_st = S_EMIT;
                        end
                        default: begin
                            n_stat = ST_NONE; n_st = S_EMIT;
                        end
                    endcase
                end
            end
            S_RD: begin
                // Wait state after a new read address, then dispatch by operation.
                case (r_op)
                    OP_INSERT: n_st = S_CHK;
                    OP_LOOKUP: n_st = S_PROBE;
                    default:   n_st = S_SCAN;
                endcase
            end
            S_CHK: begin
                if (w_skey < r_pt) begin
                    n_we = 1'b1; n_waddr = AW'(r_count); n_wdat = r_new;
                    n_slot = AW'(r_count); n_count = r_count + 1'b1; n_st = S_EMIT;
                end else begin
                    n_raddr = '0; n_idx = '0; n_st = S_FIND;
                end
            end
            S_FIND: begin
                // Address idx was set last cycle; data arrives now via S_FIND loop.
                if (r_raddr == AW'(r_idx) && r_idx != '1 && w_skey >= r_pt) begin
                    n_slot = AW'(r_idx);
                    n_idx = r_count;
                    n_raddr = AW'(r_count - 1'b1);
                    n_st = S_SHIFT;
                    n_b = '0;
                end else if (r_raddr == AW'(r_idx) && r_idx != '1) begin
                    n_idx = r_idx + 1'b1;
                    n_raddr = AW'(r_idx + 1'b1);
                    n_b = '1;       // makes the next pass a wait that holds index and read address
                end
                if (r_b == '1) begin
                    n_b = '0;
                    n_idx = r_idx;
                    n_raddr = r_raddr;
                    n_st = S_FIND;
                end
            end
            S_SHIFT: begin
                // r_idx is the destination; source idx-1 is read into r_rdat before it is written.
                if (r_b == '0) begin
                    n_b = CW'(1);
                end else if (r_idx == {1'b0, r_slot}) begin
                    n_we = 1'b1; n_waddr = r_slot; n_wdat = r_new;
                    n_count = r_count + 1'b1; n_st = S_EMIT;
                end else begin
                    n_we = 1'b1; n_waddr = AW'(r_idx); n_wdat = r_rdat;
                    n_idx = r_idx - 1'b1;
                    if (r_idx - 1'b1 != {1'b0, r_slot}) begin
                        n_raddr = AW'(r_idx - 2'd2);
                        n_b = '0;
                    end
                end
            end
            S_PROBE: begin
                if (r_pt < w_skey) begin
                    if (r_cache == '0) begin
                        n_stat = ST_NONE; n_st = S_EMIT;
                    end else begin
                        n_e = {1'b0, r_cache} - 1'b1;
                    end
                end else if (w_ekey <= r_pt) begin
                    n_b = {1'b0, r_cache} + 1'b1;
                end else begin
                    n_stat = ST_OK; n_slot = r_cache; n_hit = r_rdat; n_st = S_EMIT;
                end
                if (n_st == S_PROBE) begin
                    if (n_b <= n_e) begin
                        w_mid = CW'(({1'b0, n_b} + {1'b0, n_e}) >> 1);
                        n_cache = AW'(w_mid);
                        n_raddr = AW'(w_mid);
                        n_st = S_RD;
                    end else begin
                        w_mid = CW'(({1'b0, n_b} + {1'b0, n_e}) >> 1);
                        n_cache = AW'(w_mid);
                        n_stat = ST_NONE; n_st = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (!w_neg) begin
                    if (r_op == OP_NEXT) begin
                        if (w_skey > r_pt && (!r_have || w_skey < r_bkey)) begin
                            n_have = 1'b1; n_bkey = w_skey;
                            n_best = AW'(r_idx); n_bent = r_rdat;
                        end
                    end else begin
                        if (w_ekey <= r_pt && (!r_have || w_ekey > r_bkey)) begin
                            n_have = 1'b1; n_bkey = w_ekey;
                            n_best = AW'(r_idx); n_bent = r_rdat;
                        end
                    end
                end
                if (r_idx + 1'b1 >= r_count) begin
                    n_stat = n_have ? ST_OK : ST_NONE;
                    n_slot = n_have ? n_best : '0;
                    n_hit  = n_have ? n_bent : '0;
                    n_st = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_raddr = AW'(r_idx + 1'b1);
                    n_st = S_RD;
                end
            end
            S_EMIT: begin
                n_done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_count <= '0; r_cache <= '0; r_done <= 1'b0; r_we <= 1'b0;
        end else begin
            r_st <= n_st; r_count <= n_count; r_cache <= n_cache;
            r_done <= n_done; r_we <= n_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_pt <= n_pt; r_new <= n_new; r_idx <= n_idx;
        r_b <= n_b; r_e <= n_e; r_have <= n_have; r_best <= n_best;
        r_bkey <= n_bkey; r_bent <= n_bent; r_stat <= n_stat; r_slot <= n_slot;
        r_hit <= n_hit; r_raddr <= n_raddr; r_waddr <= n_waddr; r_wdat <= n_wdat;
    end

    assign o_done   = r_done;
    assign o_status = r_stat;
    assign o_slot   = SLOT_BITS'(r_slot);
    assign {o_hit_line, o_hit_column, o_hit_stop_line, o_hit_stop_column, o_hit_tag} = r_hit;
endmodule

/* design/sst_checker.sv */
// Port-level checker for the sorted span table, bound to the top level.
// Uses sst_pkg for the status codes.
module sst_checker import sst_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [15:0] o_hit_line,
    input logic [15:0] o_hit_tag
);
    ap_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_NONE || o_status == ST_FULL))
        else $error("bad status code");
    ap_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NONE) |-> (o_hit_line == '0 && o_hit_tag == '0))
        else $error("nothing-found result carries data");
    ap_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");
    ap_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("activity right after reset");
endmodule

bind sorted_span_table sst_checker u_sst_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_status, .o_hit_line, .o_hit_tag
);

/* verif/sorted_span_table_tb.sv */
// Testbench for sorted_span_table: directed and random command traffic checked
// against a span table predictor held in a scoreboard class. Depends on sst_pkg.
`timescale 1ns / 100ps

module sorted_span_table_tb import sst_pkg::*;;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [15:0] hit_line;
        logic [11:0] hit_column;
        logic [15:0] hit_stop_line;
        logic [11:0] hit_stop_column;
        logic [15:0] hit_tag;
    } t_span_reply;

    class span_scoreboard;
        logic [15:0] start_ln [DEPTH];
        logic [11:0] start_col[DEPTH];
        logic [15:0] stop_ln  [DEPTH];
        logic [11:0] stop_col [DEPTH];
        logic [15:0] tag_of   [DEPTH];
        int count;
        int cache;
        int errors;
        t_span_reply replies[$];

        function new();
            count = 0;
            cache = 0;
            errors = 0;
        endfunction

        function logic [27:0] skey(int i);
            return {start_ln[i], start_col[i]};
        endfunction

        function logic [27:0] ekey(int i);
            return {stop_ln[i], stop_col[i]};
        endfunction

        function t_span_reply hit(int i);
            t_span_reply r;
            r.status = ST_OK;
            r.slot = i[7:0];
            r.hit_line = start_ln[i];
            r.hit_column = start_col[i];
            r.hit_stop_line = stop_ln[i];
            r.hit_stop_column = stop_col[i];
            r.hit_tag = tag_of[i];
            return r;
        endfunction

        // Predicts the reply to one accepted transaction and updates the table.
        function void note(logic [2:0] cmd, logic [15:0] ln, logic [11:0] col,
                           logic [15:0] sln, logic [11:0] scol, logic [15:0] tg);
            t_span_reply r;
            logic [27:0] pt;
            int at, b, e, p, best;
            bit have;
            pt = {ln, col};
            r = '{default: '0};
            r.status = ST_NONE;
            case (cmd)
                CMD_INSERT: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        at = count;
                        if (count != 0 && skey(count - 1) >= pt) begin
                            for (at = 0; at < count; at++)
                                if (skey(at) >= pt) break;
                            for (int i = count; i > at; i--) begin
                                start_ln[i] = start_ln[i-1];
                                start_col[i] = start_col[i-1];
                                stop_ln[i] = stop_ln[i-1];
                                stop_col[i] = stop_col[i-1];
                                tag_of[i] = tag_of[i-1];
                            end
                        end
                        start_ln[at] = ln;
                        start_col[at] = col;
                        stop_ln[at] = sln;
                        stop_col[at] = scol;
                        tag_of[at] = tg;
                        count++;
                        r.status = ST_OK;
                        r.slot = at[7:0];
                    end
                end
                CMD_LOOKUP: begin
                    if (count != 0) begin
                        if (cache >= count) cache = 0;
                        b = 0;
                        e = count - 1;
                        while (b <= e) begin
                            p = cache;
                            if (pt < skey(p)) begin
                                if (p == 0) break;
                                e = p - 1;
                            end else if (ekey(p) <= pt) begin
                                b = p + 1;
                            end else begin
                                r = hit(p);
                                break;
                            end
                            cache = (b + e) / 2;
                        end
                    end
                end
                CMD_NEXT, CMD_PREV: begin
                    have = 0;
                    best = 0;
                    for (int i = 0; i < count; i++) begin
                        if (tag_of[i][15]) continue;
                        if (cmd == CMD_NEXT) begin
                            if (skey(i) > pt && (!have || skey(i) < skey(best))) begin
                                best = i;
                                have = 1;
                            end
                        end else if (ekey(i) <= pt && (!have || ekey(i) > ekey(best))) begin
                            best = i;
                            have = 1;
                        end
                    end
                    if (have) r = hit(best);
                end
                CMD_CLEAR: begin
                    count = 0;
                    r.status = ST_OK;
                end
                default: ;
            endcase
            replies.insert(replies.size(), r);
        endfunction

        function void check(t_span_reply got);
            t_span_reply exp;
            if (replies.size() == 0) begin
                $error("unexpected result, status %0d", got.status);
                errors++;
                return;
            end
            exp = replies.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $error("slot: expected %0d, actual %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.hit_line !== exp.hit_line) begin
                $error("hit_line: expected %0d, actual %0d", exp.hit_line, got.hit_line);
                errors++;
            end
            if (got.hit_column !== exp.hit_column) begin
                $error("hit_column: expected %0d, actual %0d",
                       exp.hit_column, got.hit_column);
                errors++;
            end
            if (got.hit_stop_line !== exp.hit_stop_line) begin
                $error("hit_stop_line: expected %0d, actual %0d",
                       exp.hit_stop_line, got.hit_stop_line);
                errors++;
            end
            if (got.hit_stop_column !== exp.hit_stop_column) begin
                $error("hit_stop_column: expected %0d, actual %0d",
                       exp.hit_stop_column, got.hit_stop_column);
                errors++;
            end
            if (got.hit_tag !== exp.hit_tag) begin
                $error("hit_tag: expected %0d, actual %0d",
                       $signed(exp.hit_tag), $signed(got.hit_tag));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_cmd = '0;
    logic [15:0] i_line = '0;
    logic [11:0] i_column = '0;
    logic [15:0] i_stop_line = '0;
    logic [11:0] i_stop_column = '0;
    logic [15:0] i_tag = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [7:0]  o_slot;
    logic [15:0] o_hit_line;
    logic [11:0] o_hit_column;
    logic [15:0] o_hit_stop_line;
    logic [11:0] o_hit_stop_column;
    logic [15:0] o_hit_tag;

    span_scoreboard sb = new();
    int quiet_cycles = 0;

    sorted_span_table uut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check('{o_status, o_slot, o_hit_line, o_hit_column,
                       o_hit_stop_line, o_hit_stop_column, o_hit_tag});
    end

    // Counts cycles in which no transaction is accepted and no result appears.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** sorted_span_table: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(logic [2:0] cmd, logic [15:0] ln, logic [11:0] col,
                        logic [15:0] sln = 0, logic [11:0] scol = 0, logic [15:0] tg = 0);
        start <= 1'b1;
        i_cmd <= cmd;
        i_line <= ln;
        i_column <= col;
        i_stop_line <= sln;
        i_stop_column <= scol;
        i_tag <= tg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note(cmd, ln, col, sln, scol, tg);
    endtask

    task automatic pause();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 80);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.replies.size() != 0) @(posedge i_clk);
    endtask

    // Mostly a narrow range so that spans overlap and searches hit.
    function automatic logic [15:0] pick_line();
        return ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    endfunction

    function automatic logic [11:0] pick_column();
        return ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, 15)) : 12'($urandom);
    endfunction

    task automatic random_insert();
        logic [15:0] ln;
        logic [11:0] col;
        ln = pick_line();
        col = pick_column();
        if ($urandom_range(0, 9) < 8)
            send(CMD_INSERT, ln, col, ln + 16'($urandom_range(0, 2)),
                 col + 12'($urandom_range(0, 20)), 16'($urandom));
        else
            send(CMD_INSERT, ln, col, 16'($urandom), 12'($urandom), 16'($urandom));
    endtask

    initial begin
        int r, cap;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, ordering, ties and unknown commands.
        send(CMD_LOOKUP, 0, 0);
        send(CMD_NEXT, 0, 0);
        send(CMD_PREV, 16'hFFFF, 12'hFFF);
        send(CMD_INSERT, 5, 10, 5, 20, 16'sd3);
        send(CMD_INSERT, 16'hFFFF, 12'hFFF, 16'hFFFF, 12'hFFF, 16'h7FFF);
        send(CMD_INSERT, 0, 0, 1, 0, 16'h8000);
        send(CMD_INSERT, 5, 10, 6, 0, 16'd0);
        send(CMD_INSERT, 2, 4, 2, 8, 16'd7);
        send(CMD_LOOKUP, 5, 15);
        send(CMD_LOOKUP, 0, 0);
        send(CMD_LOOKUP, 3, 0);
        send(CMD_LOOKUP, 16'hFFFF, 12'hFFF);
        send(CMD_NEXT, 2, 4);
        send(CMD_NEXT, 16'hFFFF, 12'hFFF);
        send(CMD_PREV, 5, 20);
        send(CMD_PREV, 0, 0);
        send(3'd5, 1, 1);
        send(3'd6, 16'hFFFF, 12'hFFF);
        send(3'd7, 0, 0);
        send(CMD_LOOKUP, 5, 25);
        // Cache left high, then the table shrinks: the cache is stale.
        send(CMD_CLEAR, 0, 0);
        send(CMD_INSERT, 1, 0, 1, 5, 16'd1);
        send(CMD_LOOKUP, 1, 2);
        drain();

        // Fill the table in reverse order so each insert after the first shifts, then overflow.
        for (int i = 0; i < DEPTH; i++)
            send(CMD_INSERT, 16'(DEPTH - i), 12'(i), 16'(DEPTH - i), 12'(i + 3), 16'(i));
        send(CMD_INSERT, 7, 7, 8, 8, 16'd9);
        send(CMD_LOOKUP, 100, 160);
        send(CMD_NEXT, 100, 0);
        send(CMD_PREV, 100, 200);
        send(CMD_CLEAR, 0, 0);
        drain();

        for (int i = 0; i < 1670; i++) begin
            cap = (i % 600 < 450) ? 24 : DEPTH + 4;
            r = $urandom_range(0, 99);
            if (sb.count >= cap && r < 50)
                send(CMD_CLEAR, 16'($urandom), 12'($urandom));
            else if (r < 38)
                random_insert();
            else if (r < 68)
                send(CMD_LOOKUP, pick_line(), pick_column(), 16'($urandom),
                     12'($urandom), 16'($urandom));
            else if (r < 81)
                send(CMD_NEXT, pick_line(), pick_column());
            else if (r < 94)
                send(CMD_PREV, pick_line(), pick_column());
            else if (r < 97)
                send(CMD_CLEAR, 16'($urandom), 12'($urandom));
            else
                send(3'($urandom_range(5, 7)), 16'($urandom), 12'($urandom));
            if (i % 400 == 399)
                drain();
            else
                pause();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** sorted_span_table: PASSED **");
        else
            $display("** sorted_span_table: FAILED **");
        $finish;
    end

endmodule

/* files.f */
design/sst_pkg.sv
design/sst_front.sv
design/sst_back.sv
design/sorted_span_table.sv
design/sst_checker.sv
verif/sorted_span_table_tb.sv
